### rtl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg: shared types, constants and helpers
// Widths, calibration register indexes and 32-bit wrap arithmetic helpers.
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int unsigned DW     = 32;  // datapath width, wraps mod 2^32
	localparam int unsigned CFG_AW = 3;   // register index width
	localparam int unsigned IN_W   = 32;  // s_axis tdata width
	localparam int unsigned OUT_W  = 40;  // m_axis tdata width

	typedef logic [DW-1:0] word_t;

	// calibration register indexes
	localparam logic [CFG_AW-1:0] REG_AC1   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_AC2   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_AC3   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_AC4   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_AC5   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_AC6   = 3'd5;
	localparam logic [CFG_AW-1:0] REG_B1_B2 = 3'd6;
	localparam logic [CFG_AW-1:0] REG_MC_MD = 3'd7;

	// compensation constants
	localparam word_t C_B6_OFS   = 32'd4000;
	localparam word_t C_B4_OFS   = 32'd32768;
	localparam word_t C_B7_GAIN  = 32'd50000;
	localparam word_t C_P_SQ     = 32'd3038;
	localparam word_t C_P_LIN    = 32'hFFFF_E343;  // -7357
	localparam word_t C_P_OFS    = 32'd3791;
	localparam word_t C_ROUND_T  = 32'd8;
	localparam word_t C_ROUND_2  = 32'd2;
	localparam word_t C_TRUNC_4  = 32'd3;
	localparam int signed T_MIN  = -32768;
	localparam int signed T_MAX  = 32767;
	localparam int signed P_MAX  = 262143;

	function automatic word_t mul_lo(input word_t a, input word_t b);
		logic [2*DW-1:0] f;
		f = a * b;
		return f[DW-1:0];
	endfunction

	function automatic word_t asr(input word_t v, input int unsigned n);
		return word_t'($signed(v) >>> n);
	endfunction

	function automatic word_t sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### rtl/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, W stages, with sideband.
// ----------------------------------------------------------------------------
module bptc_div #(
	parameter int unsigned W      = bptc_pkg::DW,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W-1:0]      num,
	input  logic [W-1:0]      den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [W-1:0]      quot,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [0:W];
	logic [W-1:0]      rem_s  [0:W];
	logic [W-1:0]      num_s  [0:W];
	logic [W-1:0]      den_s  [0:W];
	logic [W-1:0]      quo_s  [0:W];
	logic [SIDE_W-1:0] side_s [0:W];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] trial;
		logic       ge;
		logic [W:0] diff;

		always_comb begin
			trial = {rem_s[i], num_s[i][W-1]};
			ge    = (trial >= {1'b0, den_s[i]});
			diff  = trial - {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
				num_s[i+1]  <= {num_s[i][W-2:0], 1'b0};
				den_s[i+1]  <= den_s[i];
				quo_s[i+1]  <= {quo_s[i][W-2:0], ge};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quot      = quo_s[W];
	assign out_side  = side_s[W];

endmodule

### rtl/barometer_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation: integer sensor compensation
// Raw temperature/pressure pair in, tenths of a degree and pascals out.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one raw pair per transaction, m_axis one result per
//    transaction, in order. Calibration words are written through cfg_we /
//    cfg_addr / cfg_wdata while no transaction is in flight.
//  - The pipeline has 3 front stages, a 32-stage divider for the
//    temperature term, 8 stages for the pressure coefficients, a second
//    32-stage divider for the pressure quotient and 3 output stages.
//  - Throughput is one item per cycle unless m_axis stalls; every stage holds
//    at most one item and the two dividers retire one quotient bit per stage.
//  - A zero divisor in either division sets tuser (div_fault) and forces
//    both result fields to zero. Outputs are saturated to their ranges.
//  - Reset clears the calibration registers and all valid bits; payload
//    registers are not reset.
//  - When m_axis stalls with a result pending, the whole pipeline holds
//    (one shared clock enable) and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bptc_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [15:0] raw_temp, [31:16] raw_press
	input  logic [bptc_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] temp_tenths, [33:16] press_pa, [39:34] zero
	output logic [bptc_pkg::OUT_W-1:0]    m_axis_tdata,
	// [0] div_fault
	output logic                          m_axis_tuser
);

	localparam int unsigned DW = bptc_pkg::DW;
	localparam int unsigned S1_W = 16 + DW + 2;  // up, x1, neg, fault
	localparam int unsigned S2_W = DW + 2;       // b5, big, fault

	// calibration registers
	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
	logic [31:0] b1b2_q, mcmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q  <= '0;
			ac2_q  <= '0;
			ac3_q  <= '0;
			ac4_q  <= '0;
			ac5_q  <= '0;
			ac6_q  <= '0;
			b1b2_q <= '0;
			mcmd_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bptc_pkg::REG_AC1:   ac1_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_AC2:   ac2_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_AC3:   ac3_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_AC4:   ac4_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_AC5:   ac5_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_AC6:   ac6_q  <= cfg_wdata[15:0];
				bptc_pkg::REG_B1_B2: b1b2_q <= cfg_wdata;
				bptc_pkg::REG_MC_MD: mcmd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe; output register frees on handshake
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---------------- front: temperature term and first divide -------------
	logic              v_s1, v_s2, v_s3;
	bptc_pkg::word_t   d1_s1, prod1_s2;
	logic [15:0]       up_s1, up_s2;
	bptc_pkg::word_t   num_s3, den_s3;
	logic [S1_W-1:0]   side_s3;

	bptc_pkg::word_t   x1_c, den_c, num_c;

	always_comb begin
		x1_c  = bptc_pkg::asr(prod1_s2, 15);
		den_c = x1_c + bptc_pkg::sx16(mcmd_q[15:0]);
		num_c = bptc_pkg::sx16(mcmd_q[31:16]) << 11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1    <= {16'b0, s_axis_tdata[15:0]} - {16'b0, ac6_q};
			up_s1    <= s_axis_tdata[31:16];
			prod1_s2 <= bptc_pkg::mul_lo(d1_s1, {16'b0, ac5_q});
			up_s2    <= up_s1;
			num_s3   <= num_c[DW-1] ? -num_c : num_c;
			den_s3   <= den_c[DW-1] ? -den_c : den_c;
			side_s3  <= {up_s2, x1_c, num_c[DW-1] ^ den_c[DW-1], den_c == '0};
		end
	end

	logic            v_d1;
	bptc_pkg::word_t q1;
	logic [S1_W-1:0] side_d1;

	bptc_div #(.W(DW), .SIDE_W(S1_W)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.num      (num_s3),
		.den      (den_s3),
		.side     (side_s3),
		.out_valid(v_d1),
		.quot     (q1),
		.out_side (side_d1)
	);

	// ---------------- middle: pressure coefficients ------------------------
	logic            v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [15:0]     up_s4, up_s5, up_s6, up_s7, up_s8;
	logic            f_s4, f_s5, f_s6, f_s7, f_s8, f_s9, f_s10, f_s11;
	bptc_pkg::word_t b5_s4, b5_s5, b5_s6, b5_s7, b5_s8, b5_s9, b5_s10;
	bptc_pkg::word_t b6_s4;
	bptc_pkg::word_t sqp_s5, a2_s5, a3_s5;
	bptc_pkg::word_t sq_s6, x1a_s6, x1c_s6;
	bptc_pkg::word_t b2sq_s7, b1sq_s7, x1a_s7, x1c_s7;
	bptc_pkg::word_t b3_s8, sv_s8;
	bptc_pkg::word_t b4p_s9, diff_s9;
	bptc_pkg::word_t b4_s10, b7_s10;
	bptc_pkg::word_t num_s11, den_s11;
	logic [S2_W-1:0] side_s11;

	bptc_pkg::word_t x2_c, b5_c, x3_c, bn_c, xb_c;

	always_comb begin
		x2_c = side_d1[1] ? -q1 : q1;
		b5_c = side_d1[DW+1:2] + x2_c;
		x3_c = bptc_pkg::asr(b2sq_s7, 11) + x1a_s7;
		bn_c = (bptc_pkg::sx16(ac1_q) << 2) + x3_c + bptc_pkg::C_ROUND_2;
		xb_c = bptc_pkg::asr(x1c_s7 + bptc_pkg::asr(b1sq_s7, 16)
			+ bptc_pkg::C_ROUND_2, 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s4  <= v_d1;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s4: temperature intermediate
			b5_s4  <= b5_c;
			b6_s4  <= b5_c - bptc_pkg::C_B6_OFS;
			up_s4  <= side_d1[S1_W-1 -: 16];
			f_s4   <= side_d1[0];
			// s5: products on b6
			sqp_s5 <= bptc_pkg::mul_lo(b6_s4, b6_s4);
			a2_s5  <= bptc_pkg::mul_lo(bptc_pkg::sx16(ac2_q), b6_s4);
			a3_s5  <= bptc_pkg::mul_lo(bptc_pkg::sx16(ac3_q), b6_s4);
			b5_s5  <= b5_s4;
			up_s5  <= up_s4;
			f_s5   <= f_s4;
			// s6: scaling
			sq_s6  <= bptc_pkg::asr(sqp_s5, 12);
			x1a_s6 <= bptc_pkg::asr(a2_s5, 11);
			x1c_s6 <= bptc_pkg::asr(a3_s5, 13);
			b5_s6  <= b5_s5;
			up_s6  <= up_s5;
			f_s6   <= f_s5;
			// s7: products on sq
			b2sq_s7 <= bptc_pkg::mul_lo(bptc_pkg::sx16(b1b2_q[15:0]), sq_s6);
			b1sq_s7 <= bptc_pkg::mul_lo(bptc_pkg::sx16(b1b2_q[31:16]), sq_s6);
			x1a_s7  <= x1a_s6;
			x1c_s7  <= x1c_s6;
			b5_s7   <= b5_s6;
			up_s7   <= up_s6;
			f_s7    <= f_s6;
			// s8: b3 (divide by 4 toward zero) and b4 multiplicand
			b3_s8  <= bn_c[DW-1] ? bptc_pkg::asr(bn_c + bptc_pkg::C_TRUNC_4, 2)
				: bptc_pkg::asr(bn_c, 2);
			sv_s8  <= xb_c + bptc_pkg::C_B4_OFS;
			b5_s8  <= b5_s7;
			up_s8  <= up_s7;
			f_s8   <= f_s7;
			// s9
			b4p_s9  <= bptc_pkg::mul_lo({16'b0, ac4_q}, sv_s8);
			diff_s9 <= {16'b0, up_s8} - b3_s8;
			b5_s9   <= b5_s8;
			f_s9    <= f_s8;
			// s10
			b4_s10 <= b4p_s9 >> 15;
			b7_s10 <= bptc_pkg::mul_lo(diff_s9, bptc_pkg::C_B7_GAIN);
			b5_s10 <= b5_s9;
			f_s10  <= f_s9;
			// s11: second divide operands
			num_s11  <= b7_s10[DW-1] ? b7_s10 : (b7_s10 << 1);
			den_s11  <= b4_s10;
			side_s11 <= {b5_s10, b7_s10[DW-1], f_s10 || (b4_s10 == '0)};
			f_s11    <= f_s10 || (b4_s10 == '0);
		end
	end

	logic            v_d2;
	bptc_pkg::word_t q2;
	logic [S2_W-1:0] side_d2;

	bptc_div #(.W(DW), .SIDE_W(S2_W)) u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s11 && !f_s11 || v_s11),
		.num      (num_s11),
		.den      (den_s11),
		.side     (side_s11),
		.out_valid(v_d2),
		.quot     (q2),
		.out_side (side_d2)
	);

	// ---------------- back: pressure polynomial and saturation -------------
	logic            v_s12, v_s13;
	bptc_pkg::word_t p_s12, pp_s12, m2_s12, b5_s12;
	bptc_pkg::word_t p_s13, pp3_s13, x2_s13, b5_s13;
	logic            f_s12, f_s13;

	bptc_pkg::word_t p_c, pa_c, pr_c, t_c;
	logic [15:0]     temp_c;
	logic [17:0]     press_c;

	always_comb begin
		p_c  = side_d2[1] ? (q2 << 1) : q2;
		pa_c = bptc_pkg::asr(p_c, 8);
		pr_c = p_s13 + bptc_pkg::asr(bptc_pkg::asr(pp3_s13, 16) + x2_s13
			+ bptc_pkg::C_P_OFS, 4);
		t_c  = bptc_pkg::asr(b5_s13 + bptc_pkg::C_ROUND_T, 4);
		if ($signed(t_c) < bptc_pkg::T_MIN) begin
			temp_c = 16'h8000;
		end else if ($signed(t_c) > bptc_pkg::T_MAX) begin
			temp_c = 16'h7FFF;
		end else begin
			temp_c = t_c[15:0];
		end
		if ($signed(pr_c) < 0) begin
			press_c = '0;
		end else if ($signed(pr_c) > bptc_pkg::P_MAX) begin
			press_c = '1;
		end else begin
			press_c = pr_c[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12         <= 1'b0;
			v_s13         <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s12         <= v_d2;
			v_s13         <= v_s12;
			m_axis_tvalid <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s12   <= p_c;
			pp_s12  <= bptc_pkg::mul_lo(pa_c, pa_c);
			m2_s12  <= bptc_pkg::mul_lo(bptc_pkg::C_P_LIN, p_c);
			b5_s12  <= side_d2[S2_W-1 -: DW];
			f_s12   <= side_d2[0];
			p_s13   <= p_s12;
			pp3_s13 <= bptc_pkg::mul_lo(pp_s12, bptc_pkg::C_P_SQ);
			x2_s13  <= bptc_pkg::asr(m2_s12, 16);
			b5_s13  <= b5_s12;
			f_s13   <= f_s12;
			// faulted items report zeros
			m_axis_tdata <= f_s13 ? '0 : {6'b0, press_c, temp_c};
			m_axis_tuser <= f_s13;
		end
	end

endmodule
